/* hw/rtl/brs_pkg.sv */
package brs_pkg;

	localparam int TICK_W = 10;
	localparam int MIN_W  = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_SLEEP_WAIT = 2'd0;
	localparam logic [1:0] REG_SLEEP_HOLD = 2'd1;
	localparam logic [1:0] REG_MINUTE     = 2'd2;
	localparam logic [1:0] REG_DIS_MIN    = 2'd3;

	localparam logic [TICK_W-1:0] SLEEP_WAIT_RST = TICK_W'(600);
	localparam logic [TICK_W-1:0] SLEEP_HOLD_RST = TICK_W'(600);
	localparam logic [TICK_W-1:0] MINUTE_RST     = TICK_W'(600);
	localparam logic [MIN_W-1:0]  DIS_MIN_RST    = MIN_W'(5);

	typedef struct packed {
		logic charge;
		logic discharge;
		logic supply;
		logic fault_line;
	} relay_t;

endpackage

/* hw/rtl/battery_relay_sequencer.sv */
// Channel   Handshake                 Beat contents
// cfg       psel/penable/pwrite       4 timer registers, APB, pready tied high
// in        in_valid/in_ready         one control tick: lock, error, charger, sleep flags
// out       out_valid/out_ready       charge/discharge/supply relay drives, fault line
//
// One beat per cycle sustained while out_ready is high; each result is registered.
// The counter update and relay decode are a single combinational pass into a
// two-entry output buffer, so input keeps flowing while one result is stalled.
// in_ready drops only when both output entries are full.
// Reset loads register defaults and clears counters and the output buffer.
module battery_relay_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [brs_pkg::ADDR_W-1:0]    paddr,
	input  logic [brs_pkg::DATA_W-1:0]    pwdata,
	output logic [brs_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          over_temp_lock,
	input  logic                          over_charge_current_lock,
	input  logic                          cell_over_voltage_err,
	input  logic                          over_temp_err,
	input  logic                          over_charge_current_err,
	input  logic                          charger_low,
	input  logic                          sleep_request,
	input  logic                          system_fault,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          charge_relay_on,
	output logic                          discharge_relay_on,
	output logic                          supply_relay_on,
	output logic                          fault_line_on
);
	import brs_pkg::*;

	logic [TICK_W-1:0] sleep_wait_ticks_q;
	logic [TICK_W-1:0] sleep_hold_ticks_q;
	logic [TICK_W-1:0] minute_ticks_q;
	logic [MIN_W-1:0]  discharge_minutes_q;

	logic [TICK_W-1:0] sleep_wait_count_q, sleep_wait_count_d;
	logic [TICK_W-1:0] sleep_hold_count_q, sleep_hold_count_d;
	logic [TICK_W-1:0] minute_tick_count_q, minute_tick_count_d;
	logic [MIN_W-1:0]  discharge_minute_count_q, discharge_minute_count_d;

	relay_t res_d, head_q, skid_q;
	logic   head_vld_q, skid_vld_q;
	logic   push, pop, cfg_wr;
	logic   chg_ok;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_SLEEP_WAIT: prdata = DATA_W'(sleep_wait_ticks_q);
			REG_SLEEP_HOLD: prdata = DATA_W'(sleep_hold_ticks_q);
			REG_MINUTE:     prdata = DATA_W'(minute_ticks_q);
			REG_DIS_MIN:    prdata = DATA_W'(discharge_minutes_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_wait_ticks_q  <= SLEEP_WAIT_RST;
			sleep_hold_ticks_q  <= SLEEP_HOLD_RST;
			minute_ticks_q      <= MINUTE_RST;
			discharge_minutes_q <= DIS_MIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_W-1:2])
				REG_SLEEP_WAIT: sleep_wait_ticks_q  <= pwdata[TICK_W-1:0];
				REG_SLEEP_HOLD: sleep_hold_ticks_q  <= pwdata[TICK_W-1:0];
				REG_MINUTE:     minute_ticks_q      <= pwdata[TICK_W-1:0];
				REG_DIS_MIN:    discharge_minutes_q <= pwdata[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign chg_ok = !(over_temp_lock || over_charge_current_lock || cell_over_voltage_err
		|| over_temp_err || over_charge_current_err);

	always_comb begin
		sleep_wait_count_d       = sleep_wait_count_q;
		sleep_hold_count_d       = sleep_hold_count_q;
		minute_tick_count_d      = minute_tick_count_q;
		discharge_minute_count_d = discharge_minute_count_q;
		res_d.charge     = chg_ok;
		res_d.discharge  = 1'b0;
		res_d.supply     = 1'b0;
		res_d.fault_line = !system_fault;
		if (!charger_low) begin
			minute_tick_count_d      = '0;
			discharge_minute_count_d = '0;
			if (sleep_request) begin
				if (sleep_wait_count_q < sleep_wait_ticks_q) begin
					sleep_wait_count_d = sleep_wait_count_q + 1'b1;
					res_d.supply       = 1'b1;
				end else begin
					sleep_wait_count_d = sleep_wait_ticks_q;
					if (sleep_hold_count_q < sleep_hold_ticks_q) begin
						sleep_hold_count_d = sleep_hold_count_q + 1'b1;
						res_d.supply       = 1'b1;
					end else begin
						sleep_hold_count_d = sleep_hold_ticks_q;
						res_d.charge       = 1'b0;
					end
				end
			end else begin
				res_d.supply       = 1'b1;
				sleep_wait_count_d = '0;
				sleep_hold_count_d = '0;
			end
		end else begin
			sleep_wait_count_d = '0;
			sleep_hold_count_d = '0;
			res_d.charge       = 1'b0;
			if (discharge_minute_count_q < discharge_minutes_q) begin
				res_d.discharge = 1'b1;
				res_d.supply    = 1'b1;
				if (minute_tick_count_q >= minute_ticks_q) begin
					discharge_minute_count_d = discharge_minute_count_q + 1'b1;
					minute_tick_count_d      = TICK_W'(1);
				end else begin
					minute_tick_count_d = minute_tick_count_q + 1'b1;
				end
			end else begin
				discharge_minute_count_d = discharge_minutes_q;
			end
		end
	end

	assign in_ready = !skid_vld_q;
	assign push     = in_valid && in_ready;
	assign pop      = head_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_wait_count_q       <= '0;
			sleep_hold_count_q       <= '0;
			minute_tick_count_q      <= '0;
			discharge_minute_count_q <= '0;
		end else if (push) begin
			sleep_wait_count_q       <= sleep_wait_count_d;
			sleep_hold_count_q       <= sleep_hold_count_d;
			minute_tick_count_q      <= minute_tick_count_d;
			discharge_minute_count_q <= discharge_minute_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !head_vld_q) begin
			if (skid_vld_q) begin
				head_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !head_vld_q) begin
			head_q <= skid_vld_q ? skid_q : res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign out_valid          = head_vld_q;
	assign charge_relay_on    = head_q.charge;
	assign discharge_relay_on = head_q.discharge;
	assign supply_relay_on    = head_q.supply;
	assign fault_line_on      = head_q.fault_line;

endmodule
